[rtl/mcbs_pkg.sv]
// Shared types, codes and helper functions for the maze carver and solver.
// No dependencies; imported by mcbs_ctrl, the top level and the checker.
`default_nettype none

package mcbs_pkg;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] PH_CARVE = 2'd0;
    localparam logic [1:0] PH_SOLVE = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    localparam logic [3:0] ALL_WALLS = 4'hF;
    localparam logic [9:0] DIST_NONE = 10'h3FF;

    // Wall bit on this side and on the far side, per direction N, E, S, W
    localparam logic [3:0] SIDE_BIT [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [3:0] FAR_BIT  [4] = '{4'd4, 4'd8, 4'd1, 4'd2};

    typedef struct packed {
        logic [3:0] walls;
        logic       vis;
        logic [9:0] distance;
        logic [9:0] pred;
    } cell_word_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [8:0] cell_res;
        logic [3:0] walls;
        logic [9:0] distance;
        logic [9:0] pred;
    } result_t;

    // Value modulo 3 by summing base-4 digits (4 is 1 mod 3)
    function automatic logic [1:0] mod3_8(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6)
            return 2'(t - 3'd6);
        else if (t >= 3'd3)
            return 2'(t - 3'd3);
        else
            return t[1:0];
    endfunction

    // pick modulo a candidate count of 1 to 4
    function automatic logic [1:0] pick_mod(input logic [7:0] p, input logic [2:0] nc);
        logic [1:0] r;
        case (nc)
            3'd2:    r = {1'b0, p[0]};
            3'd3:    r = mod3_8(p);
            3'd4:    r = p[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/mcbs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/mcbs_ctrl.sv]
// Command sequencer: carve and solve moves as read-modify-write over the cell RAM
// and the stack/queue RAM. Depends on mcbs_pkg and mcbs_ram.
`default_nettype none

module mcbs_ctrl import mcbs_pkg::*; #(
    parameter int GRID_W = 32,
    parameter int GRID_H = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] rand_pick,
    input  wire logic [8:0] read_index,
    input  wire logic [8:0] target_cell,
    output logic            idle,
    output logic            res_valid,
    input  wire logic       res_ready,
    output result_t         res
);

    localparam int NCELLS = GRID_W * GRID_H;
    localparam int CW = $clog2(NCELLS);
    localparam int DW = CW + 1;
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam int LW = XW + YW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SWEEP  = 4'd1;
    localparam logic [3:0] S_REP    = 4'd2;
    localparam logic [3:0] S_REPW   = 4'd3;
    localparam logic [3:0] S_OUT    = 4'd4;
    localparam logic [3:0] S_C_TOP  = 4'd5;
    localparam logic [3:0] S_C_RD   = 4'd6;
    localparam logic [3:0] S_C_DEC  = 4'd7;
    localparam logic [3:0] S_C_WN   = 4'd8;
    localparam logic [3:0] S_S_HEAD = 4'd9;
    localparam logic [3:0] S_S_CAP  = 4'd10;
    localparam logic [3:0] S_S_NRD  = 4'd11;
    localparam logic [3:0] S_S_NCHK = 4'd12;

    function automatic logic [CW-1:0] cell_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return CW'(int'(y) * GRID_W + int'(x));
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] head_reg, head_next;
    logic [DW-1:0] tail_reg, tail_next;
    logic [XW-1:0] cx_reg, cx_next;
    logic [YW-1:0] cy_reg, cy_next;
    logic [2:0]    k_reg, k_next;
    logic [1:0]    dsel_reg, dsel_next;
    logic [7:0]    pick_reg, pick_next;
    cell_word_t    cw_reg, cw_next;
    cell_word_t    nb_reg [4];
    cell_word_t    nb_next [4];
    logic [DW-1:0] sw_cnt_reg, sw_cnt_next;
    logic          sw_mode_reg, sw_mode_next;
    logic          sw_wv_reg, sw_wv_next;
    logic          sw_init_reg, sw_init_next;
    logic [CW-1:0] sw_wa_reg, sw_wa_next;
    logic [CW-1:0] rep_addr_reg, rep_addr_next;
    logic [8:0]    rep_cell_reg, rep_cell_next;
    result_t       res_reg, res_next;

    logic          cm_we;
    logic [CW-1:0] cm_waddr, cm_raddr;
    cell_word_t    cm_wdata, cm_rdata;
    logic          lm_we;
    logic [CW-1:0] lm_waddr, lm_raddr;
    logic [LW-1:0] lm_wdata, lm_rdata;

    logic [XW-1:0] n_x [4];
    logic [YW-1:0] n_y [4];
    logic          n_in [4];
    logic [CW-1:0] n_idx [4];
    logic [CW-1:0] c_idx;
    logic [CW-1:0] head_idx;
    logic [DW-1:0] depth_m1;
    logic [3:0]    cand;
    logic [2:0]    nc;
    logic [1:0]    m_sel;
    logic [1:0]    d_sel;
    logic [2:0]    seen;
    logic [XW-1:0] lx;
    logic [YW-1:0] ly;

    mcbs_ram #(.WIDTH($bits(cell_word_t)), .DEPTH(NCELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    mcbs_ram #(.WIDTH(LW), .DEPTH(NCELLS)) u_list_ram (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    // Neighbor coordinates of the cell held in cx/cy, order N, E, S, W
    always_comb
    begin
        n_x[0] = cx_reg;
        n_y[0] = cy_reg - 1'b1;
        n_x[1] = cx_reg + 1'b1;
        n_y[1] = cy_reg;
        n_x[2] = cx_reg;
        n_y[2] = cy_reg + 1'b1;
        n_x[3] = cx_reg - 1'b1;
        n_y[3] = cy_reg;
        n_in[0] = (cy_reg != '0);
        n_in[1] = (32'(cx_reg) != GRID_W - 1);
        n_in[2] = (32'(cy_reg) != GRID_H - 1);
        n_in[3] = (cx_reg != '0);
        for (int d = 0; d < 4; d++)
        begin
            n_idx[d] = cell_of(n_x[d], n_y[d]);
        end
    end

    assign c_idx    = cell_of(cx_reg, cy_reg);
    assign lx       = lm_rdata[XW-1:0];
    assign ly       = lm_rdata[LW-1:XW];
    assign head_idx = cell_of(lx, ly);
    assign depth_m1 = depth_reg - 1'b1;

    // Carve choice: the m-th unvisited in-grid neighbor
    always_comb
    begin
        for (int d = 0; d < 4; d++)
        begin
            cand[d] = n_in[d] && !nb_reg[d].vis;
        end
        nc    = 3'($countones(cand));
        m_sel = pick_mod(pick_reg, nc);
        d_sel = 2'd0;
        seen  = 3'd0;
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d])
            begin
                if (seen == {1'b0, m_sel})
                begin
                    d_sel = 2'(d);
                end
                seen = seen + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cur_next      = cur_reg;
        depth_next    = depth_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        k_next        = k_reg;
        dsel_next     = dsel_reg;
        pick_next     = pick_reg;
        cw_next       = cw_reg;
        nb_next       = nb_reg;
        sw_cnt_next   = sw_cnt_reg;
        sw_mode_next  = sw_mode_reg;
        sw_wv_next    = sw_wv_reg;
        sw_init_next  = sw_init_reg;
        sw_wa_next    = sw_wa_reg;
        rep_addr_next = rep_addr_reg;
        rep_cell_next = rep_cell_reg;
        res_next      = res_reg;
        cm_we         = 1'b0;
        cm_waddr      = '0;
        cm_wdata      = cm_rdata;
        cm_raddr      = '0;
        lm_we         = 1'b0;
        lm_waddr      = '0;
        lm_wdata      = '0;
        lm_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rep_addr_next = cur_reg;
                    rep_cell_next = 9'(cur_reg);
                    state_next    = S_REP;
                    case (cmd)
                        CMD_RESTART:
                        begin
                            phase_next    = PH_CARVE;
                            cur_next      = '0;
                            depth_next    = DW'(1);
                            head_next     = '0;
                            tail_next     = '0;
                            lm_we         = 1'b1;
                            sw_mode_next  = 1'b0;
                            sw_cnt_next   = '0;
                            sw_wv_next    = 1'b0;
                            rep_addr_next = '0;
                            rep_cell_next = '0;
                            state_next    = S_SWEEP;
                        end
                        CMD_STEP:
                        begin
                            case (phase_reg)
                                PH_CARVE:
                                begin
                                    if (depth_reg == '0)
                                    begin
                                        // Stack empty: clear distances, seed queue with cell 0
                                        phase_next    = PH_SOLVE;
                                        cur_next      = '0;
                                        head_next     = '0;
                                        tail_next     = DW'(1);
                                        lm_we         = 1'b1;
                                        sw_mode_next  = 1'b1;
                                        sw_cnt_next   = '0;
                                        sw_wv_next    = 1'b0;
                                        rep_addr_next = '0;
                                        rep_cell_next = '0;
                                        state_next    = S_SWEEP;
                                    end
                                    else
                                    begin
                                        lm_raddr   = depth_m1[CW-1:0];
                                        pick_next  = rand_pick;
                                        state_next = S_C_TOP;
                                    end
                                end
                                PH_SOLVE:
                                begin
                                    if (head_reg >= tail_reg)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        lm_raddr   = head_reg[CW-1:0];
                                        head_next  = head_reg + 1'b1;
                                        state_next = S_S_HEAD;
                                    end
                                end
                                default:
                                begin
                                    state_next = S_REP;
                                end
                            endcase
                        end
                        CMD_READ:
                        begin
                            if (32'(read_index) >= NCELLS)
                            begin
                                res_next   = '{phase: phase_reg, cell_res: read_index,
                                               walls: '0, distance: DIST_NONE,
                                               pred: DIST_NONE};
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rep_addr_next = CW'(read_index);
                                rep_cell_next = read_index;
                            end
                        end
                        default:
                        begin
                            state_next = S_REP;
                        end
                    endcase
                end
            end

            S_SWEEP:
            begin
                // Entry 0 of the stack and of the queue both hold cell 0 afterwards
                lm_we = 1'b1;
                // Read one entry ahead, write back the previous one
                if (32'(sw_cnt_reg) < NCELLS)
                begin
                    cm_raddr    = sw_cnt_reg[CW-1:0];
                    sw_wa_next  = sw_cnt_reg[CW-1:0];
                    sw_wv_next  = 1'b1;
                    sw_cnt_next = sw_cnt_reg + 1'b1;
                end
                else
                begin
                    sw_wv_next = 1'b0;
                end
                if (sw_wv_reg)
                begin
                    cm_we    = 1'b1;
                    cm_waddr = sw_wa_reg;
                    if (sw_mode_reg)
                    begin
                        cm_wdata.walls    = cm_rdata.walls;
                        cm_wdata.vis      = cm_rdata.vis;
                        cm_wdata.distance = (sw_wa_reg == '0) ? '0 : DIST_NONE;
                        cm_wdata.pred     = DIST_NONE;
                    end
                    else
                    begin
                        cm_wdata.walls    = ALL_WALLS;
                        cm_wdata.vis      = (sw_wa_reg == '0);
                        cm_wdata.distance = DIST_NONE;
                        cm_wdata.pred     = DIST_NONE;
                    end
                    if (32'(sw_wa_reg) == NCELLS - 1)
                    begin
                        // The sweep after reset reports nothing
                        sw_init_next = 1'b0;
                        state_next   = sw_init_reg ? S_IDLE : S_REP;
                    end
                end
            end

            S_REP:
            begin
                cm_raddr   = rep_addr_reg;
                state_next = S_REPW;
            end

            S_REPW:
            begin
                res_next   = '{phase: phase_reg, cell_res: rep_cell_reg,
                               walls: cm_rdata.walls, distance: cm_rdata.distance,
                               pred: cm_rdata.pred};
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_C_TOP:
            begin
                cx_next    = lx;
                cy_next    = ly;
                k_next     = '0;
                state_next = S_C_RD;
            end

            S_C_RD:
            begin
                // Issue reads: current cell, then N, E, S, W; capture each in the next cycle
                if (k_reg == 3'd0)
                begin
                    cm_raddr = c_idx;
                end
                else if (k_reg != 3'd5)
                begin
                    cm_raddr = n_in[2'(k_reg - 3'd1)] ? n_idx[2'(k_reg - 3'd1)] : c_idx;
                end
                if (k_reg == 3'd1)
                begin
                    cw_next = cm_rdata;
                end
                else if (k_reg != 3'd0)
                begin
                    nb_next[2'(k_reg - 3'd2)] = cm_rdata;
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = S_C_DEC;
                end
            end

            S_C_DEC:
            begin
                if (nc == 3'd0)
                begin
                    depth_next    = depth_m1;
                    cur_next      = c_idx;
                    rep_addr_next = c_idx;
                    rep_cell_next = 9'(c_idx);
                    state_next    = S_REP;
                end
                else
                begin
                    dsel_next      = d_sel;
                    cm_we          = 1'b1;
                    cm_waddr       = c_idx;
                    cm_wdata       = cw_reg;
                    cm_wdata.walls = cw_reg.walls & ~SIDE_BIT[d_sel];
                    lm_we          = 1'b1;
                    lm_waddr       = depth_reg[CW-1:0];
                    lm_wdata       = {n_y[d_sel], n_x[d_sel]};
                    depth_next     = depth_reg + 1'b1;
                    state_next     = S_C_WN;
                end
            end

            S_C_WN:
            begin
                cm_we          = 1'b1;
                cm_waddr       = n_idx[dsel_reg];
                cm_wdata       = nb_reg[dsel_reg];
                cm_wdata.walls = nb_reg[dsel_reg].walls & ~FAR_BIT[dsel_reg];
                cm_wdata.vis   = 1'b1;
                cur_next       = n_idx[dsel_reg];
                rep_addr_next  = n_idx[dsel_reg];
                rep_cell_next  = 9'(n_idx[dsel_reg]);
                state_next     = S_REP;
            end

            S_S_HEAD:
            begin
                cx_next       = lx;
                cy_next       = ly;
                cur_next      = head_idx;
                rep_addr_next = head_idx;
                rep_cell_next = 9'(head_idx);
                if (32'(head_idx) == 32'(target_cell))
                begin
                    phase_next = PH_DONE;
                    state_next = S_REP;
                end
                else
                begin
                    cm_raddr   = head_idx;
                    state_next = S_S_CAP;
                end
            end

            S_S_CAP:
            begin
                cw_next    = cm_rdata;
                k_next     = '0;
                state_next = S_S_NRD;
            end

            S_S_NRD:
            begin
                if (k_reg == 3'd4)
                begin
                    state_next = S_REP;
                end
                else if (!cw_reg.walls[k_reg[1:0]] && n_in[k_reg[1:0]])
                begin
                    cm_raddr   = n_idx[k_reg[1:0]];
                    state_next = S_S_NCHK;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end

            S_S_NCHK:
            begin
                if (cm_rdata.distance == DIST_NONE && 32'(tail_reg) < NCELLS)
                begin
                    cm_we             = 1'b1;
                    cm_waddr          = n_idx[k_reg[1:0]];
                    cm_wdata.distance = cw_reg.distance + 10'd1;
                    cm_wdata.pred     = 10'(c_idx);
                    lm_we             = 1'b1;
                    lm_waddr          = tail_reg[CW-1:0];
                    lm_wdata          = {n_y[k_reg[1:0]], n_x[k_reg[1:0]]};
                    tail_next         = tail_reg + 1'b1;
                end
                k_next     = k_reg + 3'd1;
                state_next = S_S_NRD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            phase_reg   <= PH_CARVE;
            cur_reg     <= '0;
            depth_reg   <= DW'(1);
            head_reg    <= '0;
            tail_reg    <= '0;
            k_reg       <= '0;
            sw_cnt_reg  <= '0;
            sw_mode_reg <= 1'b0;
            sw_wv_reg   <= 1'b0;
            sw_init_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            depth_reg   <= depth_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            k_reg       <= k_next;
            sw_cnt_reg  <= sw_cnt_next;
            sw_mode_reg <= sw_mode_next;
            sw_wv_reg   <= sw_wv_next;
            sw_init_reg <= sw_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        dsel_reg     <= dsel_next;
        pick_reg     <= pick_next;
        cw_reg       <= cw_next;
        nb_reg       <= nb_next;
        sw_wa_reg    <= sw_wa_next;
        rep_addr_reg <= rep_addr_next;
        rep_cell_reg <= rep_cell_next;
        res_reg      <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/maze_carve_and_bfs_solve.sv]
// Each command returns one result. Carve and solve steps are paced by the cell RAM port, and a
// solve step reads each in-grid neighbor behind an open side.
// Restart and the start of solving sweep every cell once.
// One item at a time; the next is taken while a result waits in the output register.
// Reset clears control state, sets target_cell to 511, then sweeps the cell RAM with
// s_tready low.
`default_nettype none

module maze_carve_and_bfs_solve import mcbs_pkg::*; #(
    parameter int GRID_W = 32,
    parameter int GRID_H = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rand_pick[7:0], read_index[16:8], zero pad
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // phase[1:0], cell_res[10:2], walls[14:11],
                                        // distance[24:15], came_from[34:25], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data   // target_cell
);

    logic       idle;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    logic [8:0] target_reg;
    logic       m_valid_reg;
    result_t    m_data_reg;

    assign s_tready  = idle;
    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    mcbs_ctrl #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_tvalid && s_tready),
        .cmd         (s_tuser),
        .rand_pick   (s_tdata[7:0]),
        .read_index  (s_tdata[16:8]),
        .target_cell (target_reg),
        .idle        (idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= 9'd511;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result only when the output register is free or draining
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg.pred, m_data_reg.distance, m_data_reg.walls,
                       m_data_reg.cell_res, m_data_reg.phase};

endmodule

`default_nettype wire

[rtl/mcbs_checker.sv]
// Port-level checks on the maze carver and solver, bound to the top level.
// Depends on mcbs_pkg.
`default_nettype none

module mcbs_checker import mcbs_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // A stalled result transaction holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: busy right after accepting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Once solving has started, the start cell sits at distance 0 with no predecessor
    a_start_cell: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != PH_CARVE && m_tdata[10:2] == 9'd0
        |-> m_tdata[24:15] == 10'd0 && m_tdata[34:25] == DIST_NONE)
        else $error("start cell distance or predecessor wrong");

    // An unreached cell has no predecessor
    a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24:15] == DIST_NONE |-> m_tdata[34:25] == DIST_NONE)
        else $error("unreached cell has a predecessor");

endmodule

bind maze_carve_and_bfs_solve mcbs_checker u_mcbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
